// File: design/sm83rfa_pkg.sv
package sm83rfa_pkg;

  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);

  // Register file slots
  localparam logic [REG_IDX_W-1:0] REG_A = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_F = REG_IDX_W'(1);

  // Upper nibble of F holds Z N H C, lower nibble reads zero
  localparam logic [7:0] F_MASK  = 8'hf0;
  localparam logic [7:0] DAA_HI  = 8'h60;
  localparam logic [7:0] DAA_LO  = 8'h06;
  localparam logic [7:0] DAA_MAX = 8'h99;

  typedef enum logic [4:0] {
    ACT_RD8   = 5'd0,
    ACT_WR8   = 5'd1,
    ACT_RD16  = 5'd2,
    ACT_WR16  = 5'd3,
    ACT_INC   = 5'd4,
    ACT_DEC   = 5'd5,
    ACT_INC16 = 5'd6,
    ACT_DEC16 = 5'd7,
    ACT_ADD   = 5'd8,
    ACT_SUB   = 5'd9,
    ACT_ADD16 = 5'd10,
    ACT_DAA   = 5'd11,
    ACT_RL    = 5'd12,
    ACT_RR    = 5'd13,
    ACT_SLA   = 5'd14,
    ACT_SRA   = 5'd15,
    ACT_SRL   = 5'd16,
    ACT_AND   = 5'd17,
    ACT_OR    = 5'd18,
    ACT_XOR   = 5'd19,
    ACT_CP    = 5'd20,
    ACT_SWAP  = 5'd21,
    ACT_BIT   = 5'd22,
    ACT_SET   = 5'd23,
    ACT_RES   = 5'd24,
    ACT_RLA   = 5'd25,
    ACT_RRA   = 5'd26,
    ACT_COPY  = 5'd27
  } action_e;

  // Where the result byte goes
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,  // plain register read back
    KIND_TARGET = 2'd1,  // result to the target register or to memory
    KIND_ACC    = 2'd2,  // result to A
    KIND_BYTE   = 2'd3   // result byte reported only
  } kind_e;

  // Z N H C, bit 3 down to bit 0
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

endpackage

// File: design/sm83_register_file_alu_unit.sv
// Flow: an accepted request waits in the input register until the result register
//   is free or draining, then its result is captured there and out_valid_o rises.
// Throughput: one request per cycle unless the output stalls; the input register
//   and the result register form a two-stage pipeline; the register file is written
//   as a request leaves it, so the next request always sees up-to-date registers.
// Reset: A,F,B,C,D,E,H,L clear to zero and both pipeline stages empty.
module sm83_register_file_alu_unit import sm83rfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  action_i,
  input  logic [2:0]  register_index_i,
  input  logic [1:0]  pair_index_i,
  input  logic [2:0]  source_register_i,
  input  logic [7:0]  operand_byte_i,
  input  logic [15:0] operand_word_i,
  input  logic        use_carry_i,
  input  logic [2:0]  bit_index_i,
  input  logic        on_memory_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_byte_o,
  output logic [15:0] read_word_o,
  output logic        memory_write_o,
  output logic [15:0] memory_address_o,
  output logic [7:0]  memory_data_o,
  output logic [3:0]  flags_out_o
);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic        s1_valid_q;
  logic [4:0]  act_q;
  logic [2:0]  ri_q;
  logic [1:0]  pi_q;
  logic [2:0]  si_q;
  logic [7:0]  ob_q;
  logic [15:0] ow_q;
  logic        uc_q;
  logic [2:0]  bi_q;
  logic        mem_q;

  logic        out_valid_q;
  logic        advance;
  logic        in_fire;

  // The stage advances whenever the result register is free or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q <= action_i;
      ri_q  <= register_index_i;
      pi_q  <= pair_index_i;
      si_q  <= source_register_i;
      ob_q  <= operand_byte_i;
      ow_q  <= operand_word_i;
      uc_q  <= use_carry_i;
      bi_q  <= bit_index_i;
      mem_q <= on_memory_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Register file and ALU
  // ---------------------------------------------------------------------------
  logic [REG_COUNT-1:0][7:0] regs_q, regs_d;

  action_e                act;
  flags_t                 flg_old;
  logic [REG_IDX_W-1:0]   hi_idx, lo_idx;
  logic [15:0]            addr;
  logic [7:0]             x_reg, x, a;
  logic                   rmw;

  assign act     = action_e'(act_q);
  assign flg_old = flags_t'(regs_q[REG_F][7:4]);
  assign hi_idx  = {pi_q, 1'b0};
  assign lo_idx  = {pi_q, 1'b1};
  assign addr    = {regs_q[hi_idx], regs_q[lo_idx]};
  assign x_reg   = regs_q[ri_q];
  assign a       = regs_q[REG_A];

  // Read-modify-write forms take the byte from memory instead of the register.
  always_comb begin
    rmw = 1'b0;
    if (mem_q) begin
      unique case (act)
        ACT_INC, ACT_DEC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA, ACT_SRL,
        ACT_SWAP, ACT_BIT, ACT_SET, ACT_RES: rmw = 1'b1;
        default: rmw = 1'b0;
      endcase
    end
  end
  assign x = rmw ? ob_q : x_reg;

  logic [7:0]           res;
  flags_t               flg;
  kind_e                kind;
  logic                 byte_wr;
  logic [REG_IDX_W-1:0] byte_idx;
  logic [7:0]           byte_data;
  logic                 pair_wr;
  logic [15:0]          pair_val;
  logic                 mem_wr;

  always_comb begin
    logic       cin;
    logic [8:0] sum9;
    logic [4:0] nib5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [7:0] src;
    logic [7:0] daa_r;
    logic       daa_c;
    logic       cbit;

    res       = 8'd0;
    flg       = flg_old;
    kind      = KIND_READ;
    byte_wr   = 1'b0;
    byte_idx  = ri_q;
    byte_data = ob_q;
    pair_wr   = 1'b0;
    pair_val  = ow_q;
    cin       = uc_q && flg_old.c;
    sum9      = 9'd0;
    nib5      = 5'd0;
    sum17     = 17'd0;
    sum13     = 13'd0;
    src       = x;
    daa_r     = a;
    daa_c     = flg_old.c;
    cbit      = 1'b0;

    unique case (act)
      ACT_RD8, ACT_RD16: begin
      end
      ACT_WR8: begin
        byte_wr = 1'b1;
      end
      ACT_WR16: begin
        pair_wr = 1'b1;
      end
      ACT_INC: begin
        res  = x + 8'd1;
        kind = KIND_TARGET;
        flg  = '{z: res == 8'd0, n: 1'b0, h: x[3:0] == 4'hf, c: flg_old.c};
      end
      ACT_DEC: begin
        res  = x - 8'd1;
        kind = KIND_TARGET;
        flg  = '{z: res == 8'd0, n: 1'b1, h: x[3:0] == 4'h0, c: flg_old.c};
      end
      ACT_INC16: begin
        pair_wr  = 1'b1;
        pair_val = addr + 16'd1;
      end
      ACT_DEC16: begin
        pair_wr  = 1'b1;
        pair_val = addr - 16'd1;
      end
      ACT_ADD: begin
        sum9 = {1'b0, x_reg} + {1'b0, ob_q} + {8'd0, cin};
        nib5 = {1'b0, x_reg[3:0]} + {1'b0, ob_q[3:0]} + {4'd0, cin};
        res  = sum9[7:0];
        kind = KIND_TARGET;
        flg  = '{z: res == 8'd0, n: 1'b0, h: nib5[4], c: sum9[8]};
      end
      ACT_SUB: begin
        // Bit above the top goes high exactly on a borrow.
        sum9 = {1'b0, x_reg} - {1'b0, ob_q} - {8'd0, cin};
        nib5 = {1'b0, x_reg[3:0]} - {1'b0, ob_q[3:0]} - {4'd0, cin};
        res  = sum9[7:0];
        kind = KIND_TARGET;
        flg  = '{z: res == 8'd0, n: 1'b1, h: nib5[4], c: sum9[8]};
      end
      ACT_ADD16: begin
        sum17    = {1'b0, addr} + {1'b0, ow_q};
        sum13    = {1'b0, addr[11:0]} + {1'b0, ow_q[11:0]};
        pair_wr  = 1'b1;
        pair_val = sum17[15:0];
        flg      = '{z: flg_old.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end
      ACT_DAA: begin
        if (!flg_old.n) begin
          if (flg_old.c || a > DAA_MAX) begin
            daa_r = daa_r + DAA_HI;
            daa_c = 1'b1;
          end
          if (flg_old.h || daa_r[3:0] > 4'd9) begin
            daa_r = daa_r + DAA_LO;
          end
        end else begin
          if (flg_old.c) begin
            daa_r = daa_r - DAA_HI;
          end
          if (flg_old.h) begin
            daa_r = daa_r - DAA_LO;
          end
        end
        res  = daa_r;
        kind = KIND_ACC;
        flg  = '{z: res == 8'd0, n: flg_old.n, h: 1'b0, c: daa_c};
      end
      ACT_RL, ACT_RLA: begin
        src  = (act == ACT_RLA) ? a : x;
        cbit = uc_q ? src[7] : flg_old.c;
        res  = {src[6:0], cbit};
        kind = (act == ACT_RLA) ? KIND_ACC : KIND_TARGET;
        flg  = '{z: (act == ACT_RL) && (res == 8'd0), n: 1'b0, h: 1'b0, c: src[7]};
      end
      ACT_RR, ACT_RRA: begin
        src  = (act == ACT_RRA) ? a : x;
        cbit = uc_q ? src[0] : flg_old.c;
        res  = {cbit, src[7:1]};
        kind = (act == ACT_RRA) ? KIND_ACC : KIND_TARGET;
        flg  = '{z: (act == ACT_RR) && (res == 8'd0), n: 1'b0, h: 1'b0, c: src[0]};
      end
      ACT_SLA: begin
        res  = {x[6:0], 1'b0};
        kind = KIND_TARGET;
        flg  = '{z: res == 8'd0, n: 1'b0, h: 1'b0, c: x[7]};
      end
      ACT_SRA: begin
        res  = {x[7], x[7:1]};
        kind = KIND_TARGET;
        flg  = '{z: res == 8'd0, n: 1'b0, h: 1'b0, c: x[0]};
      end
      ACT_SRL: begin
        res  = {1'b0, x[7:1]};
        kind = KIND_TARGET;
        flg  = '{z: res == 8'd0, n: 1'b0, h: 1'b0, c: x[0]};
      end
      ACT_AND: begin
        res  = a & ob_q;
        kind = KIND_ACC;
        flg  = '{z: res == 8'd0, n: 1'b0, h: 1'b1, c: 1'b0};
      end
      ACT_OR: begin
        res  = a | ob_q;
        kind = KIND_ACC;
        flg  = '{z: res == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_XOR: begin
        res  = a ^ ob_q;
        kind = KIND_ACC;
        flg  = '{z: res == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_CP: begin
        sum9 = {1'b0, a} - {1'b0, ob_q};
        nib5 = {1'b0, a[3:0]} - {1'b0, ob_q[3:0]};
        res  = sum9[7:0];
        kind = KIND_BYTE;
        flg  = '{z: res == 8'd0, n: 1'b1, h: nib5[4], c: sum9[8]};
      end
      ACT_SWAP: begin
        res  = {x[3:0], x[7:4]};
        kind = KIND_TARGET;
        flg  = '{z: res == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ACT_BIT: begin
        res  = x;
        kind = KIND_BYTE;
        flg  = '{z: !x[bi_q], n: 1'b0, h: 1'b1, c: flg_old.c};
      end
      ACT_SET: begin
        res  = x | (8'd1 << bi_q);
        kind = KIND_TARGET;
      end
      ACT_RES: begin
        res  = x & ~(8'd1 << bi_q);
        kind = KIND_TARGET;
      end
      ACT_COPY: begin
        byte_wr   = 1'b1;
        byte_data = regs_q[si_q];
      end
      default: begin
      end
    endcase

    // Route the result byte: memory for read-modify-write, else a register, unless only reported.
    mem_wr = (kind == KIND_TARGET) && rmw;
    if (kind == KIND_TARGET && !rmw) begin
      byte_wr   = 1'b1;
      byte_idx  = ri_q;
      byte_data = res;
    end else if (kind == KIND_ACC) begin
      byte_wr   = 1'b1;
      byte_idx  = REG_A;
      byte_data = res;
    end
  end

  // F only ever takes the new flags, unless an ALU result targets F directly.
  always_comb begin
    regs_d = regs_q;
    if (pair_wr) begin
      regs_d[hi_idx] = pair_val[15:8];
      regs_d[lo_idx] = pair_val[7:0];
    end
    if (byte_wr) begin
      regs_d[byte_idx] = byte_data;
    end
    if (kind == KIND_TARGET && !rmw && ri_q == REG_F) begin
      regs_d[REG_F] = res & F_MASK;
    end else begin
      regs_d[REG_F] = {flg, 4'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (s1_valid_q && advance) begin
      regs_q <= regs_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [7:0]  read_byte_q;
  logic [15:0] read_word_q;
  logic        memory_write_q;
  logic [15:0] memory_address_q;
  logic [7:0]  memory_data_q;
  logic [3:0]  flags_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      read_byte_q      <= (kind == KIND_READ) ? regs_d[ri_q] : res;
      read_word_q      <= {regs_d[hi_idx], regs_d[lo_idx]};
      memory_write_q   <= mem_wr;
      memory_address_q <= mem_wr ? addr : 16'd0;
      memory_data_q    <= mem_wr ? res : 8'd0;
      flags_out_q      <= regs_d[REG_F][7:4];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_byte_o      = read_byte_q;
  assign read_word_o      = read_word_q;
  assign memory_write_o   = memory_write_q;
  assign memory_address_o = memory_address_q;
  assign memory_data_o    = memory_data_q;
  assign flags_out_o      = flags_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_f_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q[REG_F][3:0] == 4'd0)
    else $error("low nibble of F is not zero");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty result register");

  a_regs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && advance) |=> $stable(regs_q))
    else $error("register file changed without a request leaving the input stage");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> flags_out_o == regs_q[REG_F][7:4])
    else $error("reported flags differ from F");

  a_no_mem_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !memory_write_o) |-> (memory_address_o == 16'd0 && memory_data_o == 8'd0))
    else $error("memory address or data driven without a memory write");

endmodule

// File: test/tb_sm83_register_file_alu_unit.sv
`timescale 1ns / 1ps

module tb_sm83_register_file_alu_unit;
  import sm83rfa_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned ITEM_BUDGET  = 750;
  localparam int unsigned DRAIN_CYCLES = 8;
  // The slowest legal run stays far below this limit.
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Register slots beyond A and F, and the pair selects
  localparam logic [2:0] REG_B = 3'd2;
  localparam logic [2:0] REG_C = 3'd3;
  localparam logic [2:0] REG_D = 3'd4;
  localparam logic [2:0] REG_E = 3'd5;
  localparam logic [2:0] REG_H = 3'd6;
  localparam logic [2:0] REG_L = 3'd7;
  localparam logic [1:0] PAIR_AF = 2'd0;
  localparam logic [1:0] PAIR_BC = 2'd1;
  localparam logic [1:0] PAIR_DE = 2'd2;
  localparam logic [1:0] PAIR_HL = 2'd3;

  // Unused action codes above the last defined operation
  localparam logic [4:0] ACT_SPARE_LO = 5'd28;
  localparam logic [4:0] ACT_SPARE_HI = 5'd31;

  typedef struct {
    logic [4:0]  action;
    logic [2:0]  reg_sel;
    logic [1:0]  pair_sel;
    logic [2:0]  src_sel;
    logic [7:0]  imm_byte;
    logic [15:0] imm_word;
    logic        use_carry;
    logic [2:0]  bit_sel;
    logic        on_memory;
  } alu_request_t;

  typedef struct {
    logic [7:0]  read_byte;
    logic [15:0] read_word;
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    flags_t      flags;
  } alu_result_t;

  // Shadow register file plus the queue of results still owed by the block.
  class alu_scoreboard;
    logic [7:0]  regs [REG_COUNT];
    alu_result_t expected_results [$];
    int          mismatches;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      mismatches = 0;
    endfunction

    function logic [15:0] pair_value(logic [1:0] p);
      return {regs[{p, 1'b0}], regs[{p, 1'b1}]};
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] v);
      regs[idx] = (idx == REG_F) ? (v & F_MASK) : v;
    endfunction

    function void write_pair(logic [1:0] p, logic [15:0] v);
      write_reg({p, 1'b0}, v[15:8]);
      write_reg({p, 1'b1}, v[7:0]);
    endfunction

    function logic [7:0] flag_byte(bit z, bit n, bit h, bit c);
      return {z, n, h, c, 4'b0000};
    endfunction

    // Execute one accepted request on the shadow state and queue its result.
    function void note_request(alu_request_t q);
      logic [7:0]  f_next, x, acc, res, src;
      logic [15:0] addr;
      logic [16:0] sum17;
      logic [8:0]  sum9;
      bit          carry, cin, rmw, mem_wr, fill, n_flag, h_flag, c_flag;
      int          bcd;
      kind_e       kind;
      alu_result_t exp;

      f_next = regs[REG_F];
      carry  = f_next[4];
      addr   = pair_value(q.pair_sel);
      rmw    = q.on_memory && (q.action inside {ACT_INC, ACT_DEC, [ACT_RL:ACT_SRL],
                                                [ACT_SWAP:ACT_RES]});
      x      = rmw ? q.imm_byte : regs[q.reg_sel];
      acc    = regs[REG_A];
      res    = 8'h00;
      kind   = KIND_READ;
      mem_wr = 1'b0;

      case (q.action)
        ACT_WR8:   write_reg(q.reg_sel, q.imm_byte);
        ACT_WR16:  write_pair(q.pair_sel, q.imm_word);
        ACT_INC: begin
          res = x + 8'd1;
          kind = KIND_TARGET;
          f_next = flag_byte(res == 8'h00, 1'b0, x[3:0] == 4'hf, carry);
        end
        ACT_DEC: begin
          res = x - 8'd1;
          kind = KIND_TARGET;
          f_next = flag_byte(res == 8'h00, 1'b1, x[3:0] == 4'h0, carry);
        end
        ACT_INC16: write_pair(q.pair_sel, addr + 16'd1);
        ACT_DEC16: write_pair(q.pair_sel, addr - 16'd1);
        ACT_ADD: begin
          cin  = q.use_carry && carry;
          sum9 = {1'b0, x} + {1'b0, q.imm_byte} + 9'(cin);
          res  = sum9[7:0];
          kind = KIND_TARGET;
          f_next = flag_byte(res == 8'h00, 1'b0,
                             ({1'b0, x[3:0]} + {1'b0, q.imm_byte[3:0]} + 5'(cin)) > 5'h0f,
                             sum9[8]);
        end
        ACT_SUB: begin
          cin  = q.use_carry && carry;
          res  = x - q.imm_byte - 8'(cin);
          kind = KIND_TARGET;
          f_next = flag_byte(res == 8'h00, 1'b1,
                             {1'b0, x[3:0]} < ({1'b0, q.imm_byte[3:0]} + 5'(cin)),
                             {1'b0, x} < ({1'b0, q.imm_byte} + 9'(cin)));
        end
        ACT_ADD16: begin
          sum17  = {1'b0, addr} + {1'b0, q.imm_word};
          f_next = (f_next & 8'h80) |
                   flag_byte(1'b0, 1'b0,
                             ({1'b0, addr[11:0]} + {1'b0, q.imm_word[11:0]}) > 13'h0fff,
                             sum17[16]);
          write_pair(q.pair_sel, sum17[15:0]);
        end
        ACT_DAA: begin
          n_flag = f_next[6];
          h_flag = f_next[5];
          c_flag = carry;
          bcd    = acc;
          if (!n_flag) begin
            if (c_flag || bcd > DAA_MAX) begin
              bcd += DAA_HI;
              c_flag = 1'b1;
            end
            if (h_flag || (bcd & 'hf) > 9) bcd += DAA_LO;
          end else begin
            if (c_flag) bcd -= DAA_HI;
            if (h_flag) bcd -= DAA_LO;
          end
          res  = bcd[7:0];
          kind = KIND_ACC;
          f_next = flag_byte(res == 8'h00, n_flag, 1'b0, c_flag);
        end
        ACT_RL, ACT_RLA: begin
          src  = (q.action == ACT_RLA) ? acc : x;
          fill = q.use_carry ? src[7] : carry;
          res  = {src[6:0], fill};
          f_next = flag_byte(q.action == ACT_RL && res == 8'h00, 1'b0, 1'b0, src[7]);
          kind = (q.action == ACT_RLA) ? KIND_ACC : KIND_TARGET;
        end
        ACT_RR, ACT_RRA: begin
          src  = (q.action == ACT_RRA) ? acc : x;
          fill = q.use_carry ? src[0] : carry;
          res  = {fill, src[7:1]};
          f_next = flag_byte(q.action == ACT_RR && res == 8'h00, 1'b0, 1'b0, src[0]);
          kind = (q.action == ACT_RRA) ? KIND_ACC : KIND_TARGET;
        end
        ACT_SLA: begin
          res = {x[6:0], 1'b0};
          kind = KIND_TARGET;
          f_next = flag_byte(res == 8'h00, 1'b0, 1'b0, x[7]);
        end
        ACT_SRA: begin
          res = {x[7], x[7:1]};
          kind = KIND_TARGET;
          f_next = flag_byte(res == 8'h00, 1'b0, 1'b0, x[0]);
        end
        ACT_SRL: begin
          res = {1'b0, x[7:1]};
          kind = KIND_TARGET;
          f_next = flag_byte(res == 8'h00, 1'b0, 1'b0, x[0]);
        end
        ACT_AND: begin
          res = acc & q.imm_byte;
          kind = KIND_ACC;
          f_next = flag_byte(res == 8'h00, 1'b0, 1'b1, 1'b0);
        end
        ACT_OR: begin
          res = acc | q.imm_byte;
          kind = KIND_ACC;
          f_next = flag_byte(res == 8'h00, 1'b0, 1'b0, 1'b0);
        end
        ACT_XOR: begin
          res = acc ^ q.imm_byte;
          kind = KIND_ACC;
          f_next = flag_byte(res == 8'h00, 1'b0, 1'b0, 1'b0);
        end
        ACT_CP: begin
          res = acc - q.imm_byte;
          kind = KIND_BYTE;
          f_next = flag_byte(res == 8'h00, 1'b1, acc[3:0] < q.imm_byte[3:0],
                             acc < q.imm_byte);
        end
        ACT_SWAP: begin
          res = {x[3:0], x[7:4]};
          kind = KIND_TARGET;
          f_next = flag_byte(res == 8'h00, 1'b0, 1'b0, 1'b0);
        end
        ACT_BIT: begin
          res = x;
          kind = KIND_BYTE;
          f_next = flag_byte(!x[q.bit_sel], 1'b0, 1'b1, carry);
        end
        ACT_SET: begin
          res = x | (8'h01 << q.bit_sel);
          kind = KIND_TARGET;
        end
        ACT_RES: begin
          res = x & ~(8'h01 << q.bit_sel);
          kind = KIND_TARGET;
        end
        ACT_COPY: write_reg(q.reg_sel, regs[q.src_sel]);
        default: ;
      endcase

      // Flags land last, so a plain write to F that disagrees with them is undone;
      // a result aimed at F then overrides the flags.
      if (f_next != regs[REG_F]) regs[REG_F] = f_next & F_MASK;
      if (kind == KIND_TARGET) begin
        // bit tests only report, so every memory-form target op writes memory
        if (rmw) mem_wr = 1'b1;
        else write_reg(q.reg_sel, res);
      end else if (kind == KIND_ACC) begin
        write_reg(REG_A, res);
      end

      exp.read_byte = (kind == KIND_READ) ? regs[q.reg_sel] : res;
      exp.read_word = pair_value(q.pair_sel);
      exp.mem_write = mem_wr;
      exp.mem_addr  = mem_wr ? addr : 16'h0000;
      exp.mem_data  = mem_wr ? res : 8'h00;
      exp.flags     = regs[REG_F][7:4];
      expected_results.push_back(exp);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, seen);
        mismatches++;
      end
    endfunction

    // Compare one delivered result against the oldest outstanding one.
    function void check_result(alu_result_t seen);
      alu_result_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte %h word %h",
                 $time, seen.read_byte, seen.read_word);
        mismatches++;
        return;
      end
      exp = expected_results.pop_front();
      compare_field("read_byte",      16'(exp.read_byte), 16'(seen.read_byte));
      compare_field("read_word",      exp.read_word,      seen.read_word);
      compare_field("memory_write",   16'(exp.mem_write), 16'(seen.mem_write));
      compare_field("memory_address", exp.mem_addr,       seen.mem_addr);
      compare_field("memory_data",    16'(exp.mem_data),  16'(seen.mem_data));
      compare_field("flags_out",      16'(exp.flags),     16'(seen.flags));
    endfunction
  endclass

  // Clock, reset and DUT pins; every input starts at a known value.
  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [4:0]  action_i          = '0;
  logic [2:0]  register_index_i  = '0;
  logic [1:0]  pair_index_i      = '0;
  logic [2:0]  source_register_i = '0;
  logic [7:0]  operand_byte_i    = '0;
  logic [15:0] operand_word_i    = '0;
  logic        use_carry_i       = 1'b0;
  logic [2:0]  bit_index_i       = '0;
  logic        on_memory_i       = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [7:0]  read_byte_o;
  logic [15:0] read_word_o;
  logic        memory_write_o;
  logic [15:0] memory_address_o;
  logic [7:0]  memory_data_o;
  logic [3:0]  flags_out_o;

  // Percent of cycles in which each side holds off
  int unsigned   sender_idle_pct   = 28;
  int unsigned   receiver_idle_pct = 61;
  int unsigned   cycle_count       = 0;
  alu_scoreboard board;

  sm83_register_file_alu_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .register_index_i  (register_index_i),
    .pair_index_i      (pair_index_i),
    .source_register_i (source_register_i),
    .operand_byte_i    (operand_byte_i),
    .operand_word_i    (operand_word_i),
    .use_carry_i       (use_carry_i),
    .bit_index_i       (bit_index_i),
    .on_memory_i       (on_memory_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_byte_o       (read_byte_o),
    .read_word_o       (read_word_o),
    .memory_write_o    (memory_write_o),
    .memory_address_o  (memory_address_o),
    .memory_data_o     (memory_data_o),
    .flags_out_o       (flags_out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: sample the handshake as it stood at the edge, then pick the
  // next cycle's ready at random.
  initial begin
    alu_result_t seen;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        seen.read_byte = read_byte_o;
        seen.read_word = read_word_o;
        seen.mem_write = memory_write_o;
        seen.mem_addr  = memory_address_o;
        seen.mem_data  = memory_data_o;
        seen.flags     = flags_out_o;
        board.check_result(seen);
      end
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Present one request: idle a random number of cycles, raise valid with the
  // payload, hold it until accepted, then log it with the scoreboard.
  task automatic drive_request(input alu_request_t q);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    action_i          <= q.action;
    register_index_i  <= q.reg_sel;
    pair_index_i      <= q.pair_sel;
    source_register_i <= q.src_sel;
    operand_byte_i    <= q.imm_byte;
    operand_word_i    <= q.imm_word;
    use_carry_i       <= q.use_carry;
    bit_index_i       <= q.bit_sel;
    on_memory_i       <= q.on_memory;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(q);
  endtask

  function automatic alu_request_t make_request(logic [4:0] act, logic [2:0] ri,
                                                logic [1:0] pi, logic [2:0] si,
                                                logic [7:0] ob, logic [15:0] ow,
                                                logic uc, logic [2:0] bi, logic mem);
    alu_request_t q;
    q.action    = act;
    q.reg_sel   = ri;
    q.pair_sel  = pi;
    q.src_sel   = si;
    q.imm_byte  = ob;
    q.imm_word  = ow;
    q.use_carry = uc;
    q.bit_sel   = bi;
    q.on_memory = mem;
    return q;
  endfunction

  // Mostly defined operations with now and then a spare code; operands lean
  // toward the all-zero and all-one corners.
  function automatic alu_request_t random_request();
    alu_request_t q;
    q.action = ($urandom_range(99) < 4) ? 5'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO))
                                        : 5'($urandom_range(ACT_COPY));
    q.reg_sel   = 3'($urandom_range(7));
    q.pair_sel  = 2'($urandom_range(3));
    q.src_sel   = 3'($urandom_range(7));
    q.imm_byte  = ($urandom_range(99) < 15) ? {8{1'($urandom_range(1))}}
                                            : 8'($urandom_range(8'hff));
    q.imm_word  = ($urandom_range(99) < 15) ? {16{1'($urandom_range(1))}}
                                            : 16'($urandom_range(16'hffff));
    q.use_carry = 1'($urandom_range(1));
    q.bit_sel   = 3'($urandom_range(7));
    q.on_memory = 1'($urandom_range(1));
    return q;
  endfunction

  function automatic logic [7:0] random_bcd();
    return {4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  // Directed opener: every operation but the 16-bit read, chained so that
  // carries, wraps and the decimal-adjust corner cases actually occur.
  task automatic run_directed();
    // A = 99, then 99 + 1 and a decimal adjust wraps to zero with carry
    drive_request(make_request(ACT_WR8, REG_A, PAIR_AF, REG_A, 8'h99, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_ADD, REG_A, PAIR_AF, REG_A, 8'h01, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_DAA, REG_A, PAIR_AF, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    // subtract with borrow in: every flag set, then adjust with N, H and C
    drive_request(make_request(ACT_SUB, REG_A, PAIR_AF, REG_A, 8'hff, 16'h0000, 1, 0, 0));
    drive_request(make_request(ACT_DAA, REG_A, PAIR_AF, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    // 16-bit wrap both ways
    drive_request(make_request(ACT_WR16, REG_B, PAIR_BC, REG_A, 8'h00, 16'hffff, 0, 0, 0));
    drive_request(make_request(ACT_INC16, REG_B, PAIR_BC, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_DEC16, REG_C, PAIR_BC, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    // 16-bit add with carry out of bit 11 and bit 15
    drive_request(make_request(ACT_WR16, REG_H, PAIR_HL, REG_A, 8'h00, 16'h0fff, 0, 0, 0));
    drive_request(make_request(ACT_ADD16, REG_L, PAIR_HL, REG_A, 8'h00, 16'hf001, 0, 0, 0));
    // memory forms and register forms of the byte ops
    drive_request(make_request(ACT_INC, REG_B, PAIR_HL, REG_A, 8'hff, 16'h0000, 0, 0, 1));
    drive_request(make_request(ACT_DEC, REG_C, PAIR_BC, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_RL, REG_D, PAIR_BC, REG_A, 8'h80, 16'h0000, 0, 0, 1));
    drive_request(make_request(ACT_RR, REG_E, PAIR_DE, REG_A, 8'h01, 16'h0000, 1, 0, 0));
    drive_request(make_request(ACT_SLA, REG_H, PAIR_BC, REG_A, 8'h80, 16'h0000, 0, 0, 1));
    drive_request(make_request(ACT_SRA, REG_L, PAIR_BC, REG_A, 8'h81, 16'h0000, 0, 0, 1));
    drive_request(make_request(ACT_SRL, REG_A, PAIR_AF, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_AND, REG_A, PAIR_AF, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_OR, REG_A, PAIR_AF, REG_A, 8'hff, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_XOR, REG_A, PAIR_AF, REG_A, 8'hff, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_CP, REG_A, PAIR_AF, REG_A, 8'hff, 16'h0000, 0, 0, 0));
    // swap aimed at F itself
    drive_request(make_request(ACT_SWAP, REG_F, PAIR_AF, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    // bit test on a memory byte never writes memory
    drive_request(make_request(ACT_BIT, REG_A, PAIR_HL, REG_A, 8'h7f, 16'h0000, 0, 7, 1));
    drive_request(make_request(ACT_SET, REG_L, PAIR_HL, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_RES, REG_A, PAIR_DE, REG_A, 8'hff, 16'h0000, 0, 7, 1));
    drive_request(make_request(ACT_RLA, REG_A, PAIR_AF, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_RRA, REG_A, PAIR_AF, REG_A, 8'h00, 16'h0000, 1, 0, 0));
    drive_request(make_request(ACT_COPY, REG_B, PAIR_BC, REG_A, 8'h00, 16'h0000, 0, 0, 0));
    drive_request(make_request(ACT_RD8, REG_F, PAIR_AF, REG_A, 8'h00, 16'h0000, 0, 0, 0));
  endtask

  // Random body: mostly single random requests, with decimal sequences
  // (load A, add or subtract a BCD byte, adjust) mixed in.
  task automatic run_random(input int unsigned count);
    int unsigned  sent;
    alu_request_t q;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 12) begin
        drive_request(make_request(ACT_WR8, REG_A, PAIR_AF, REG_A, random_bcd(),
                                   16'h0000, 0, 0, 0));
        q = random_request();
        q.action    = $urandom_range(1) ? ACT_ADD : ACT_SUB;
        q.reg_sel   = REG_A;
        q.imm_byte  = random_bcd();
        drive_request(q);
        q = random_request();
        q.action = ACT_DAA;
        drive_request(q);
        sent += 3;
      end else begin
        drive_request(random_request());
        sent++;
      end
    end
  endtask

  initial begin
    board = new();
    // Hold reset at the start, then release it for good.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: sender idles lightly, receiver stalls heavily.
    sender_idle_pct   = 28;
    receiver_idle_pct = 61;
    run_directed();
    run_random(ITEM_BUDGET / 3);

    // Phase two: swap the pressure.
    sender_idle_pct   = 61;
    receiver_idle_pct = 28;
    run_random(ITEM_BUDGET / 3);

    // Phase three: back to back, no idling on either side.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random(ITEM_BUDGET / 3);
    in_valid_i <= 1'b0;

    // Drain outstanding results, then give stray outputs a chance to show.
    while (board.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
